// File: hw/rtl/ir_pulse_width_decoder_assert.svh
// ---------------------------------------------------------------------------
// ir pulse width decoder assertion macros
// shorthand for clocked properties, reset gated on arst_n
// ---------------------------------------------------------------------------
`ifndef IR_PULSE_WIDTH_DECODER_ASSERT_SVH
`define IR_PULSE_WIDTH_DECODER_ASSERT_SVH

// consequent checked in the same cycle as the antecedent
`define IRPWD_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequent checked in the cycle after the antecedent
`define IRPWD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/irpwd_pkg.sv
// ---------------------------------------------------------------------------
// irpwd_pkg
// shared types and constants of the ir pulse width decoder
// ---------------------------------------------------------------------------
`default_nettype none

package irpwd_pkg;

	// widths of the beat fields and registers
	localparam int WIDTH_W   = 16;
	localparam int COUNT_W   = 6;
	localparam int CMD_W     = 32;
	localparam int MAX_BITS  = 32;
	localparam int CFG_IDX_W = 3;
	localparam int CFG_DATA_W = WIDTH_W;

	// queue between front and back
	localparam int QDEPTH  = 2;
	localparam int QPTR_W  = $clog2(QDEPTH);
	localparam int QCNT_W  = $clog2(QDEPTH + 1);

	// register reset values
	localparam logic [WIDTH_W-1:0] START_MIN_RST = WIDTH_W'(7000);
	localparam logic [WIDTH_W-1:0] START_MAX_RST = WIDTH_W'(8500);
	localparam logic [WIDTH_W-1:0] LONG_MIN_RST  = WIDTH_W'(1200);
	localparam logic [WIDTH_W-1:0] LONG_MAX_RST  = WIDTH_W'(1400);
	localparam logic [WIDTH_W-1:0] SHORT_MIN_RST = WIDTH_W'(300);
	localparam logic [WIDTH_W-1:0] SHORT_MAX_RST = WIDTH_W'(500);
	localparam logic [COUNT_W-1:0] BIT_COUNT_RST = COUNT_W'(11);

	// register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_START_MIN = 3'd0,
		CFG_START_MAX = 3'd1,
		CFG_LONG_MIN  = 3'd2,
		CFG_LONG_MAX  = 3'd3,
		CFG_SHORT_MIN = 3'd4,
		CFG_SHORT_MAX = 3'd5,
		CFG_BIT_COUNT = 3'd6
	} cfg_idx_t;

	// decoder state
	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_RECV = 2'd1,
		ST_CHK0 = 2'd2,
		ST_CHK1 = 2'd3
	} dec_state_t;

	// register file contents
	typedef struct packed {
		logic [WIDTH_W-1:0] start_lo;
		logic [WIDTH_W-1:0] start_hi;
		logic [WIDTH_W-1:0] long_min;
		logic [WIDTH_W-1:0] long_max;
		logic [WIDTH_W-1:0] short_min;
		logic [WIDTH_W-1:0] short_max;
		logic [COUNT_W-1:0] bit_count;
	} cfg_t;

	// classified event as held in the queue
	typedef struct packed {
		logic overflow;
		logic capture;
		logic line_level;
		logic in_start;
		logic in_long;
		logic in_short;
	} evt_t;

endpackage

`default_nettype wire

// File: hw/rtl/ir_pulse_width_decoder.sv
// ---------------------------------------------------------------------------
// ir_pulse_width_decoder
// infrared remote frame decoder fed by timer edge-capture events
// ---------------------------------------------------------------------------
// Takes one edge event per clock while the queue has room: the front end
// compares the pulse width against the start, long and short windows (all
// exclusive) and drops the classified beat into a two-entry queue; the back
// end runs the frame state machine on one queued beat per cycle while the
// output can take a result, and loads the inverted, masked bit pattern into
// an output register when bit_count bits have arrived. Sustained rate is one
// event per cycle while the output is not stalled, set by the back end taking
// one queue entry a cycle. A stalled output holds its beat while up to two
// further events are queued. The user must write registers through cfg_we/
// cfg_index/cfg_data only while the decoder is idle, unenforced by the block.
`default_nettype none

module ir_pulse_width_decoder (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [irpwd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [irpwd_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  wire logic                               in_valid,
	output logic                                    in_stall,
	input  wire logic                               overflow,
	input  wire logic                               capture,
	input  wire logic                               line_level,
	input  wire logic [irpwd_pkg::WIDTH_W-1:0]      pulse_width,
	output logic                                    out_valid,
	input  wire logic                               out_stall,
	output logic [irpwd_pkg::CMD_W-1:0]             command
);

	irpwd_pkg::cfg_t  cfg;
	irpwd_pkg::evt_t  push_evt;
	irpwd_pkg::evt_t  head_evt;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_valid;

	// register file
	irpwd_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg)
	);

	// width classification
	irpwd_front u_front (
		.in_valid    (in_valid),
		.q_full      (q_full),
		.overflow    (overflow),
		.capture     (capture),
		.line_level  (line_level),
		.pulse_width (pulse_width),
		.cfg         (cfg),
		.in_stall    (in_stall),
		.push        (push),
		.push_evt    (push_evt)
	);

	// decoupling queue
	irpwd_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_evt (push_evt),
		.pop      (pop),
		.q_full   (q_full),
		.q_valid  (q_valid),
		.head_evt (head_evt)
	);

	// frame decoding
	irpwd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_valid   (q_valid),
		.head_evt  (head_evt),
		.cfg       (cfg),
		.out_stall (out_stall),
		.pop       (pop),
		.out_valid (out_valid),
		.command   (command)
	);

endmodule

`default_nettype wire

// File: hw/rtl/irpwd_cfg.sv
// ---------------------------------------------------------------------------
// irpwd_cfg
// window and frame length registers, written through the plain write port
// ---------------------------------------------------------------------------
`default_nettype none

module irpwd_cfg (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [irpwd_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  wire logic [irpwd_pkg::CFG_DATA_W-1:0]   cfg_data,
	output irpwd_pkg::cfg_t                         cfg
);

	irpwd_pkg::cfg_t cfg_q;

	// register writes, unknown indexes ignored
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.start_lo  <= irpwd_pkg::START_MIN_RST;
			cfg_q.start_hi  <= irpwd_pkg::START_MAX_RST;
			cfg_q.long_min  <= irpwd_pkg::LONG_MIN_RST;
			cfg_q.long_max  <= irpwd_pkg::LONG_MAX_RST;
			cfg_q.short_min <= irpwd_pkg::SHORT_MIN_RST;
			cfg_q.short_max <= irpwd_pkg::SHORT_MAX_RST;
			cfg_q.bit_count <= irpwd_pkg::BIT_COUNT_RST;
		end else if (cfg_we) begin
			case (irpwd_pkg::cfg_idx_t'(cfg_index))
				irpwd_pkg::CFG_START_MIN: cfg_q.start_lo  <= cfg_data;
				irpwd_pkg::CFG_START_MAX: cfg_q.start_hi  <= cfg_data;
				irpwd_pkg::CFG_LONG_MIN:  cfg_q.long_min  <= cfg_data;
				irpwd_pkg::CFG_LONG_MAX:  cfg_q.long_max  <= cfg_data;
				irpwd_pkg::CFG_SHORT_MIN: cfg_q.short_min <= cfg_data;
				irpwd_pkg::CFG_SHORT_MAX: cfg_q.short_max <= cfg_data;
				irpwd_pkg::CFG_BIT_COUNT: cfg_q.bit_count <= cfg_data[irpwd_pkg::COUNT_W-1:0];
				default: begin
				end
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

// File: hw/rtl/irpwd_front.sv
// ---------------------------------------------------------------------------
// irpwd_front
// takes edge events and sorts the pulse width into the three windows
// ---------------------------------------------------------------------------
`default_nettype none

module irpwd_front (
	input  wire logic                             in_valid,
	input  wire logic                             q_full,
	input  wire logic                             overflow,
	input  wire logic                             capture,
	input  wire logic                             line_level,
	input  wire logic [irpwd_pkg::WIDTH_W-1:0]    pulse_width,
	input  irpwd_pkg::cfg_t                       cfg,
	output logic                                  in_stall,
	output logic                                  push,
	output irpwd_pkg::evt_t                       push_evt
);

	// input beat taken whenever the queue has room
	assign in_stall = q_full;
	assign push     = in_valid && !q_full;

	// exclusive window compares
	always_comb begin
		push_evt.overflow   = overflow;
		push_evt.capture    = capture;
		push_evt.line_level = line_level;
		push_evt.in_start   = (pulse_width > cfg.start_lo) && (pulse_width < cfg.start_hi);
		push_evt.in_long    = (pulse_width > cfg.long_min)  && (pulse_width < cfg.long_max);
		push_evt.in_short   = (pulse_width > cfg.short_min) && (pulse_width < cfg.short_max);
	end

endmodule

`default_nettype wire

// File: hw/rtl/irpwd_queue.sv
// ---------------------------------------------------------------------------
// irpwd_queue
// short fifo of classified events between front and back
// ---------------------------------------------------------------------------
`default_nettype none

module irpwd_queue (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        push,
	input  irpwd_pkg::evt_t  push_evt,
	input  wire logic        pop,
	output logic             q_full,
	output logic             q_valid,
	output irpwd_pkg::evt_t  head_evt
);

	irpwd_pkg::evt_t                  mem_q [irpwd_pkg::QDEPTH];
	logic [irpwd_pkg::QPTR_W-1:0]     wr_ptr_q;
	logic [irpwd_pkg::QPTR_W-1:0]     rd_ptr_q;
	logic [irpwd_pkg::QCNT_W-1:0]     count_q;

	// entry storage
	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_evt;
		end
	end

	// pointers and fill level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == irpwd_pkg::QPTR_W'(irpwd_pkg::QDEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == irpwd_pkg::QPTR_W'(irpwd_pkg::QDEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	assign q_full   = (count_q == irpwd_pkg::QCNT_W'(irpwd_pkg::QDEPTH));
	assign q_valid  = (count_q != '0);
	assign head_evt = mem_q[rd_ptr_q];

endmodule

`default_nettype wire

// File: hw/rtl/irpwd_back.sv
// ---------------------------------------------------------------------------
// irpwd_back
// frame state machine, bit shifter and output register
// ---------------------------------------------------------------------------
`default_nettype none

module irpwd_back (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           q_valid,
	input  irpwd_pkg::evt_t                     head_evt,
	input  irpwd_pkg::cfg_t                     cfg,
	input  wire logic                           out_stall,
	output logic                                pop,
	output logic                                out_valid,
	output logic [irpwd_pkg::CMD_W-1:0]         command
);

	irpwd_pkg::dec_state_t                state_q, state_d, state_ovf;
	logic [irpwd_pkg::COUNT_W-1:0]        bits_q, bits_d;
	logic [irpwd_pkg::MAX_BITS-1:0]       shift_q, shift_d;
	logic [irpwd_pkg::MAX_BITS-1:0]       mask;
	logic                                 out_ready;
	logic                                 emit;
	logic                                 out_valid_q;
	logic [irpwd_pkg::CMD_W-1:0]          command_q;

	// one event a cycle while the output register can take a result
	assign out_ready = !out_valid_q || !out_stall;
	assign pop       = q_valid && out_ready;

	// frame length mask, saturating at the shifter width
	always_comb begin
		if (cfg.bit_count >= irpwd_pkg::COUNT_W'(irpwd_pkg::MAX_BITS)) begin
			mask = '1;
		end else begin
			mask = (irpwd_pkg::MAX_BITS'(1) << cfg.bit_count) - irpwd_pkg::MAX_BITS'(1);
		end
	end

	// next state, shifter and frame end
	always_comb begin
		state_ovf = head_evt.overflow ? irpwd_pkg::ST_IDLE : state_q;
		state_d   = state_ovf;
		bits_d    = bits_q;
		shift_d   = shift_q;
		emit      = 1'b0;
		if (head_evt.capture) begin
			case (state_ovf)
				irpwd_pkg::ST_IDLE: begin
					if (!head_evt.line_level && head_evt.in_start) begin
						bits_d  = '0;
						shift_d = '0;
						state_d = irpwd_pkg::ST_RECV;
					end
				end
				irpwd_pkg::ST_RECV: begin
					if (head_evt.line_level) begin
						if (head_evt.in_short) begin
							shift_d = {shift_q[irpwd_pkg::MAX_BITS-2:0], 1'b0};
							bits_d  = bits_q + 1'b1;
							state_d = irpwd_pkg::ST_CHK0;
						end else if (head_evt.in_long) begin
							shift_d = {shift_q[irpwd_pkg::MAX_BITS-2:0], 1'b1};
							bits_d  = bits_q + 1'b1;
							state_d = irpwd_pkg::ST_CHK1;
						end else begin
							state_d = irpwd_pkg::ST_IDLE;
						end
					end
				end
				irpwd_pkg::ST_CHK0: begin
					if (!head_evt.line_level) begin
						state_d = head_evt.in_long ? irpwd_pkg::ST_RECV : irpwd_pkg::ST_IDLE;
					end
				end
				irpwd_pkg::ST_CHK1: begin
					if (!head_evt.line_level) begin
						state_d = head_evt.in_short ? irpwd_pkg::ST_RECV : irpwd_pkg::ST_IDLE;
					end
				end
				default: begin
					state_d = irpwd_pkg::ST_IDLE;
				end
			endcase
			// count check runs after every capture
			if (bits_d == cfg.bit_count) begin
				emit    = 1'b1;
				bits_d  = '0;
				state_d = irpwd_pkg::ST_IDLE;
			end
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= irpwd_pkg::ST_IDLE;
			bits_q  <= '0;
			shift_q <= '0;
		end else if (pop) begin
			state_q <= state_d;
			bits_q  <= bits_d;
			shift_q <= shift_d;
		end
	end

	// output register, holds the beat while stalled
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (pop && emit) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (pop && emit) begin
			command_q <= irpwd_pkg::CMD_W'(~shift_d & mask);
		end
	end

	assign out_valid = out_valid_q;
	assign command   = command_q;

endmodule

`default_nettype wire

// File: hw/rtl/irpwd_checker.sv
// ---------------------------------------------------------------------------
// irpwd_checker
// port level checks of the ir pulse width decoder, bound to the top level
// ---------------------------------------------------------------------------
`default_nettype none

`include "ir_pulse_width_decoder_assert.svh"

module irpwd_checker (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               in_valid,
	input  wire logic                               in_stall,
	input  wire logic                               out_valid,
	input  wire logic                               out_stall,
	input  wire logic [irpwd_pkg::CMD_W-1:0]        command
);

	// a stalled result beat stays put
	`IRPWD_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(command), "result beat changed while stalled")

	// the queue fills only through an accepted input beat
	`IRPWD_ASSERT_NOW(a_stall_cause, $rose(in_stall), $past(in_valid), "input stall rose without an input beat")

	// a full queue drains one entry whenever the output side can move
	`IRPWD_ASSERT_NEXT(a_stall_release, in_stall && (!out_valid || !out_stall), !in_stall, "input stall held with a free output register")

endmodule

bind ir_pulse_width_decoder irpwd_checker u_irpwd_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.command   (command)
);

`default_nettype wire
